[design/paged_memory_pack_bus_slave_macros.svh]
// Assertion helpers shared by the checking code of the pack slave.
`ifndef PAGED_MEMORY_PACK_BUS_SLAVE_MACROS_SVH
`define PAGED_MEMORY_PACK_BUS_SLAVE_MACROS_SVH

// Concurrent check, quiet while reset is high.
`define PMP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent check that also holds through reset.
`define PMP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[design/pmp_pkg.sv]
`timescale 1ns / 1ps
package pmp_pkg;

  localparam int ADDR_W         = 16;
  localparam int DATA_W         = 8;
  localparam int MEM_DEPTH      = 1 << ADDR_W;
  localparam int PAGE_COUNT_DEF = 256;

  localparam logic [DATA_W-1:0] ERASED    = 8'hFF;
  localparam logic [DATA_W-1:0] MBOX_IDLE = 8'hFF;
  localparam logic [DATA_W-1:0] MBOX_DONE = 8'h00;
  localparam logic [DATA_W-1:0] BYTE_STEP = 8'd2;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_HOST_WR = 2'd1,
    CMD_HOST_RD = 2'd2,
    CMD_CLAIM = 2'd3
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic drive_en;
    logic host_rd;
    logic ready;
  } item_info_t;

endpackage

[design/paged_memory_pack_bus_slave.sv]
`timescale 1ns / 1ps
// Paged memory pack, bus slave side.
// Input channel (in_valid/in_ready) carries either one sample of the pack
// bus (cmd 0) or a host access: write byte, read byte, or mailbox claim.
// Output channel (out_valid/out_ready) returns exactly one result per input
// transfer: the driven byte and its enable, the host read byte, and the
// claim status. Unused result fields are zero.
// Each item makes at most one access to the single-port pack memory, so one
// item is accepted per cycle unless erase or a stall holds in_ready low;
// memory is read at the transfer edge, the output as the read stage moves.
// The user writes the mailbox base register through cfg_wr_en/cfg_wr_data
// only while no item is in flight; the block does not enforce it.
// After reset the whole pack memory is erased to 0xFF, one byte per cycle:
// in_ready stays low until the sweep ends; config writes are still taken.
// When the receiver stalls, the output register holds its result and one
// more item may sit in the read stage; then in_ready drops until the output
// register frees up.
module paged_memory_pack_bus_slave #(
  parameter int PAGE_COUNT = pmp_pkg::PAGE_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [pmp_pkg::ADDR_W-1:0]   cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   cmd,
  input  logic [pmp_pkg::DATA_W-1:0]   bus_data,
  input  logic                         bus_clock,
  input  logic                         page_strobe_n,
  input  logic                         counter_reset,
  input  logic                         output_enable_n,
  input  logic                         select_n,
  input  logic [pmp_pkg::ADDR_W-1:0]   host_address,
  input  logic [pmp_pkg::DATA_W-1:0]   host_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pmp_pkg::DATA_W-1:0]   drive_data,
  output logic                         drive_enable,
  output logic [pmp_pkg::DATA_W-1:0]   host_read_data,
  output logic                         command_ready
);

  `include "paged_memory_pack_bus_slave_macros.svh"

  pmp_pkg::mem_req_t          req;
  pmp_pkg::item_info_t        info, s1_info;
  logic [pmp_pkg::DATA_W-1:0] rdata;
  logic                       busy;
  logic                       accept;
  logic                       s1_valid;
  logic                       s1_move;

  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !busy && (!s1_valid || s1_move);
  assign accept   = in_valid && in_ready;

  pmp_seq #(
    .PAGE_COUNT(PAGE_COUNT)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .accept         (accept),
    .cmd            (cmd),
    .bus_data       (bus_data),
    .bus_clock      (bus_clock),
    .page_strobe_n  (page_strobe_n),
    .counter_reset  (counter_reset),
    .output_enable_n(output_enable_n),
    .select_n       (select_n),
    .host_address   (host_address),
    .host_data      (host_data),
    .req            (req),
    .info           (info)
  );

  pmp_mem u_mem (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rdata(rdata),
    .busy (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info <= info;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // capture the read stage while the old memory word is still on rdata
  always_ff @(posedge clk) begin
    if (s1_move) begin
      drive_data     <= s1_info.drive_en ? rdata : '0;
      drive_enable   <= s1_info.drive_en;
      host_read_data <= s1_info.host_rd ? rdata : '0;
      command_ready  <= s1_info.ready;
    end
  end

  `PMP_ASSERT(a_no_accept_in_erase, clk, rst, accept |-> !busy,
    "item accepted during erase sweep")
  `PMP_ASSERT(a_mem_only_on_accept, clk, rst, req.en |-> accept,
    "memory access without a transfer")
  `PMP_ASSERT(a_stall_blocks_input, clk, rst,
    (s1_valid && out_valid && !out_ready) |-> !in_ready,
    "input taken while read stage is blocked")
  `PMP_ASSERT(a_result_exclusive, clk, rst,
    (out_valid && drive_enable) |-> (host_read_data == '0 && !command_ready),
    "drive result mixed with host result")

endmodule

[design/pmp_mem.sv]
`timescale 1ns / 1ps
module pmp_mem (
  input  logic                         clk,
  input  logic                         rst,
  input  pmp_pkg::mem_req_t            req,
  output logic [pmp_pkg::DATA_W-1:0]   rdata,
  output logic                         busy
);

  logic [pmp_pkg::DATA_W-1:0] mem [pmp_pkg::MEM_DEPTH];
  logic [pmp_pkg::ADDR_W-1:0] clr_addr;

  // Erase sweep after reset, one byte per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + (pmp_pkg::ADDR_W)'(1);
      if (clr_addr == {pmp_pkg::ADDR_W{1'b1}}) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy && !rst) begin
      mem[clr_addr] <= pmp_pkg::ERASED;
    end else if (req.en && req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.en && !req.we) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

[design/pmp_seq.sv]
`timescale 1ns / 1ps
module pmp_seq #(
  parameter int PAGE_COUNT = pmp_pkg::PAGE_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [pmp_pkg::ADDR_W-1:0]   cfg_wr_data,
  input  logic                         accept,
  input  logic [1:0]                   cmd,
  input  logic [pmp_pkg::DATA_W-1:0]   bus_data,
  input  logic                         bus_clock,
  input  logic                         page_strobe_n,
  input  logic                         counter_reset,
  input  logic                         output_enable_n,
  input  logic                         select_n,
  input  logic [pmp_pkg::ADDR_W-1:0]   host_address,
  input  logic [pmp_pkg::DATA_W-1:0]   host_data,
  output pmp_pkg::mem_req_t            req,
  output pmp_pkg::item_info_t          info
);

  localparam logic [8:0] PAGE_LIMIT = 9'(PAGE_COUNT);

  logic [7:0]                 byte_counter, byte_counter_next;
  logic [7:0]                 page_counter, page_counter_next;
  logic                       prev_clock, prev_clock_next;
  logic                       prev_strobe, prev_strobe_next;
  logic [7:0]                 mailbox_remaining, mailbox_remaining_next;
  logic [pmp_pkg::ADDR_W-1:0] mailbox_base;

  logic                       clk_fall, pgm_fall;
  logic [8:0]                 page_inc;
  logic [7:0]                 byte_adv, page_adv;
  logic [pmp_pkg::ADDR_W-1:0] drive_addr, wr_addr;
  logic [pmp_pkg::ADDR_W:0]   base_diff;
  logic                       in_window;
  pmp_pkg::cmd_t              op;

  always_comb begin
    op         = pmp_pkg::cmd_t'(cmd);
    clk_fall   = prev_clock & ~bus_clock;
    pgm_fall   = prev_strobe & ~page_strobe_n;
    drive_addr = {page_counter, byte_counter | {7'b0, bus_clock}};
    byte_adv   = clk_fall ? byte_counter + pmp_pkg::BYTE_STEP : byte_counter;
    page_inc   = {1'b0, page_counter} + 9'd1;
    if (!pgm_fall) begin
      page_adv = page_counter;
    end else if (page_inc >= PAGE_LIMIT) begin
      page_adv = '0;
    end else begin
      page_adv = page_inc[7:0];
    end
    wr_addr   = {page_adv, byte_adv | {7'b0, bus_clock}};
    base_diff = {1'b0, wr_addr} - {1'b0, mailbox_base};
    in_window = (wr_addr > mailbox_base) && (base_diff[pmp_pkg::ADDR_W:8] == '0);
  end

  always_comb begin
    byte_counter_next      = byte_counter;
    page_counter_next      = page_counter;
    prev_clock_next        = prev_clock;
    prev_strobe_next       = prev_strobe;
    mailbox_remaining_next = mailbox_remaining;
    req                    = '0;
    info                   = '0;
    if (accept) begin
      case (op)
        pmp_pkg::CMD_HOST_WR: begin
          req.en    = 1'b1;
          req.we    = 1'b1;
          req.addr  = host_address;
          req.wdata = host_data;
        end
        pmp_pkg::CMD_HOST_RD: begin
          req.en       = 1'b1;
          req.addr     = host_address;
          info.host_rd = 1'b1;
        end
        pmp_pkg::CMD_CLAIM: begin
          if (mailbox_remaining == pmp_pkg::MBOX_DONE) begin
            info.ready             = 1'b1;
            mailbox_remaining_next = pmp_pkg::MBOX_IDLE;
          end
        end
        pmp_pkg::CMD_SAMPLE: begin
          prev_clock_next  = bus_clock;
          prev_strobe_next = page_strobe_n;
          if (!select_n) begin
            if (!output_enable_n) begin
              // read at the address before this sample moves the counters
              req.en        = 1'b1;
              req.addr      = drive_addr;
              info.drive_en = 1'b1;
            end
            if (counter_reset) begin
              byte_counter_next = '0;
              page_counter_next = '0;
            end else begin
              byte_counter_next = byte_adv;
              page_counter_next = page_adv;
              if (output_enable_n) begin
                req.en    = 1'b1;
                req.we    = 1'b1;
                req.addr  = wr_addr;
                req.wdata = bus_data;
                if (wr_addr == mailbox_base) begin
                  mailbox_remaining_next = bus_data;
                end else if (mailbox_remaining != pmp_pkg::MBOX_DONE &&
                             mailbox_remaining != pmp_pkg::MBOX_IDLE && in_window) begin
                  mailbox_remaining_next = mailbox_remaining - 8'd1;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_counter      <= '0;
      page_counter      <= '0;
      prev_clock        <= 1'b0;
      prev_strobe       <= 1'b0;
      mailbox_remaining <= pmp_pkg::MBOX_IDLE;
      mailbox_base      <= '0;
    end else begin
      byte_counter      <= byte_counter_next;
      page_counter      <= page_counter_next;
      prev_clock        <= prev_clock_next;
      prev_strobe       <= prev_strobe_next;
      mailbox_remaining <= mailbox_remaining_next;
      if (cfg_wr_en) begin
        mailbox_base <= cfg_wr_data;
      end
    end
  end

endmodule
